FILE: hw/rtl/dtrm_pkg.sv
// ----------------------------------------------------------------------------
// dtrm_pkg
// shared widths and stream packing constants for the dirty tile marker
// ----------------------------------------------------------------------------
package dtrm_pkg;

	// pixel coordinate width, signed
	localparam int COORD_W = 16;

	// result field widths
	localparam int TILE_ROW_W = 4;
	localparam int ROW_BITS_W = 32;

	// stream widths, padded to whole bytes
	localparam int S_TDATA_W = 4 * COORD_W;
	localparam int M_TDATA_W = 40;

	typedef logic signed [COORD_W-1:0] coord_t;

endpackage

FILE: hw/rtl/dtrm_clamp.sv
// ----------------------------------------------------------------------------
// dtrm_clamp
// converts pixel corners to tile coordinates and clamps them to the grid
// ----------------------------------------------------------------------------
module dtrm_clamp
	import dtrm_pkg::*;
#(
	parameter int TILES_WIDE = 32,
	parameter int TILES_HIGH = 16,
	parameter int TILE_SHIFT = 4,
	parameter int CW         = 5,
	parameter int RW         = 4
) (
	input  coord_t          left_x,
	input  coord_t          top_y,
	input  coord_t          right_x,
	input  coord_t          bottom_y,
	output logic            off,
	output logic [CW-1:0]   x_lo,
	output logic [CW-1:0]   x_hi,
	output logic [RW-1:0]   y_lo,
	output logic [RW-1:0]   y_hi
);

	localparam coord_t TW = COORD_W'(TILES_WIDE);
	localparam coord_t TH = COORD_W'(TILES_HIGH);

	coord_t xt1, yt1, xt2, yt2;
	coord_t cx1, cy1, cx2, cy2;

	always_comb begin
		// arithmetic shift floors toward minus infinity
		xt1 = left_x >>> TILE_SHIFT;
		yt1 = top_y >>> TILE_SHIFT;
		xt2 = right_x >>> TILE_SHIFT;
		yt2 = bottom_y >>> TILE_SHIFT;

		cx1 = (xt1 < 0) ? '0 : xt1;
		cy1 = (yt1 < 0) ? '0 : yt1;
		cx2 = (xt2 >= TW) ? TW - COORD_W'(1) : xt2;
		cy2 = (yt2 >= TH) ? TH - COORD_W'(1) : yt2;

		off = (xt1 >= TW) || (yt1 >= TH) || (xt2 < 0) || (yt2 < 0)
			|| (cx1 > cx2) || (cy1 > cy2);

		x_lo = cx1[CW-1:0];
		x_hi = cx2[CW-1:0];
		y_lo = cy1[RW-1:0];
		y_hi = cy2[RW-1:0];
	end

endmodule

FILE: hw/rtl/dtrm_row_mem.sv
// ----------------------------------------------------------------------------
// dtrm_row_mem
// dirty row store, one write and one registered read port, cleared by reset
// ----------------------------------------------------------------------------
module dtrm_row_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [WIDTH-1:0] rd_raw_q;
	logic             rd_valid_q;

	// row valid bits, a row never written reads as clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_valid_q ? rd_raw_q : '0;

endmodule

FILE: hw/rtl/dirty_tile_rect_marker_unit.sv
// ----------------------------------------------------------------------------
// dirty_tile_rect_marker_unit
// marks the tiles a pixel rectangle covers and streams the updated rows
// ----------------------------------------------------------------------------
// Each transaction on the slave side carries one signed pixel rectangle. The
// corners are shifted down to tile coordinates and clamped to a grid of
// TILES_WIDE by TILES_HIGH tiles. For every covered tile row, top to bottom,
// the row's dirty bitmap is read, the covered columns are set, the row is
// written back and one result transaction goes out with onscreen high, the
// row index and the row's updated bits; tlast marks the bottom row. A
// rectangle that covers no tile gives one transaction with onscreen low,
// zero data and tlast high, and leaves the bitmap alone. The bitmap is clear
// after reset (per-row valid bits, no clearing pass) and bits are only ever
// set. An item is accepted and decoded in ST_IDLE; each covered row then
// passes through ST_READ and ST_WRITE, as the row memory's read data is
// registered before the merge and write back, and an offscreen item passes
// through ST_OFF. ST_WRITE and ST_OFF wait while the result register is
// full. The unit is not ready while an item is in work; the result register
// lets the last result wait while the next rectangle is accepted.
// ----------------------------------------------------------------------------
module dirty_tile_rect_marker_unit
	import dtrm_pkg::*;
#(
	parameter int TILES_WIDE = 32,
	parameter int TILES_HIGH = 16,
	parameter int TILE_SHIFT = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// slave side: rectangles
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// tdata: left_x[15:0], top_y[31:16], right_x[47:32], bottom_y[63:48]
	input  logic [S_TDATA_W-1:0] s_tdata,
	// master side: marked rows
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// tdata: tile_row[3:0], row_bits[35:4], zero[39:36]
	output logic [M_TDATA_W-1:0] m_tdata,
	// tuser: onscreen[0]
	output logic                 m_tuser,
	output logic                 m_tlast
);

	// index widths, at least one bit
	localparam int CW    = (TILES_WIDE > 1) ? $clog2(TILES_WIDE) : 1;
	localparam int RW    = (TILES_HIGH > 1) ? $clog2(TILES_HIGH) : 1;
	// widened views for the fixed result fields
	localparam int BIT_E = (TILES_WIDE > ROW_BITS_W) ? TILES_WIDE : ROW_BITS_W;
	localparam int ROW_E = (RW > TILE_ROW_W) ? RW : TILE_ROW_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_OFF,
		ST_READ,
		ST_WRITE
	} state_t;

	state_t state_q;

	// decoded rectangle
	logic                  dec_off;
	logic [CW-1:0]         dec_x_lo, dec_x_hi;
	logic [RW-1:0]         dec_y_lo, dec_y_hi;

	// held rectangle for the row walk
	logic [TILES_WIDE-1:0] mask_q;
	logic [RW-1:0]         y_q;
	logic [RW-1:0]         y_hi_q;

	// column mask of the decoded span
	logic [TILES_WIDE-1:0] dec_mask;

	// row memory
	logic                  rd_en;
	logic [TILES_WIDE-1:0] rd_data;
	logic                  wr_en;
	logic [TILES_WIDE-1:0] new_row;

	// output register
	logic                  out_free;
	logic                  m_tvalid_q;
	logic [M_TDATA_W-1:0]  m_tdata_q;
	logic                  m_tuser_q;
	logic                  m_tlast_q;

	logic [BIT_E-1:0]      row_ext;
	logic [ROW_E-1:0]      y_ext;

	dtrm_clamp #(
		.TILES_WIDE (TILES_WIDE),
		.TILES_HIGH (TILES_HIGH),
		.TILE_SHIFT (TILE_SHIFT),
		.CW         (CW),
		.RW         (RW)
	) u_clamp (
		.left_x   (coord_t'(s_tdata[COORD_W-1:0])),
		.top_y    (coord_t'(s_tdata[2*COORD_W-1:COORD_W])),
		.right_x  (coord_t'(s_tdata[3*COORD_W-1:2*COORD_W])),
		.bottom_y (coord_t'(s_tdata[4*COORD_W-1:3*COORD_W])),
		.off      (dec_off),
		.x_lo     (dec_x_lo),
		.x_hi     (dec_x_hi),
		.y_lo     (dec_y_lo),
		.y_hi     (dec_y_hi)
	);

	// one compare pair per column, all independent
	always_comb begin
		for (int i = 0; i < TILES_WIDE; i++) begin
			dec_mask[i] = (CW'(i) >= dec_x_lo) && (CW'(i) <= dec_x_hi);
		end
	end

	dtrm_row_mem #(
		.DEPTH (TILES_HIGH),
		.WIDTH (TILES_WIDE),
		.AW    (RW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (y_q),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (y_q),
		.wr_data (new_row)
	);

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign rd_en    = (state_q == ST_READ);
	// merge and write back only when the result can be loaded
	assign wr_en    = (state_q == ST_WRITE) && out_free;
	assign new_row  = rd_data | mask_q;
	assign row_ext  = BIT_E'(new_row);
	assign y_ext    = ROW_E'(y_q);

	// sequencer with the registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= dec_off ? ST_OFF : ST_READ;
					end
				end
				ST_OFF: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				ST_READ: begin
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= (y_q == y_hi_q) ? ST_IDLE : ST_READ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mask_q <= dec_mask;
			y_q    <= dec_y_lo;
			y_hi_q <= dec_y_hi;
		end
		if (state_q == ST_OFF && out_free) begin
			m_tdata_q <= '0;
			m_tuser_q <= 1'b0;
			m_tlast_q <= 1'b1;
		end
		if (wr_en) begin
			m_tdata_q <= M_TDATA_W'({row_ext[ROW_BITS_W-1:0], y_ext[TILE_ROW_W-1:0]});
			m_tuser_q <= 1'b1;
			m_tlast_q <= (y_q == y_hi_q);
			// step to the next covered row
			if (y_q != y_hi_q) begin
				y_q <= y_q + RW'(1);
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule
